// File: rtl/kpc_pkg.sv
// ----------------------------------------------------------------------------
// kpc_pkg
// Types and codes shared by the key press classifier.
// ----------------------------------------------------------------------------
package kpc_pkg;

    localparam int CountW = 16;
    localparam int ClickW = 8;
    localparam int EventW = 3;
    localparam int RegIdxW = 3;

    // Key phase, one-hot
    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_PRESSED = 4'b0010,
        PH_LONG    = 4'b0100,
        PH_REPEAT  = 4'b1000
    } phase_t;

    // Reported events
    typedef enum logic [EventW-1:0] {
        EV_NONE         = 3'd0,
        EV_PRESS        = 3'd1,
        EV_LONG         = 3'd2,
        EV_REPEAT       = 3'd3,
        EV_RELEASE      = 3'd4,
        EV_LONG_RELEASE = 3'd5
    } event_t;

    // Register indexes (byte address = 4 * index)
    localparam logic [RegIdxW-1:0] REG_SHORT_THR  = 3'd0;
    localparam logic [RegIdxW-1:0] REG_LONG_THR   = 3'd1;
    localparam logic [RegIdxW-1:0] REG_REL_DELAY  = 3'd2;
    localparam logic [RegIdxW-1:0] REG_REPEAT_EN  = 3'd3;
    localparam logic [RegIdxW-1:0] REG_MULTI_EN   = 3'd4;

    localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
    localparam logic [ClickW-1:0] ClickMax = {ClickW{1'b1}};

    // Add with saturation at the counter maximum
    function automatic logic [CountW-1:0] sat_add(input logic [CountW-1:0] a,
                                                 input logic [CountW-1:0] b);
        logic [CountW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CountW] ? CountMax : s[CountW-1:0];
    endfunction

endpackage

// File: rtl/key_press_classifier_unit.sv
// ----------------------------------------------------------------------------
// key_press_classifier_unit
// Classifies one sampled key level per scan tick into press, long press,
// repeat, release and long release events, with multi-click counting.
// ----------------------------------------------------------------------------
// One beat on the input channel carries one key sample (key_down, 1 = held)
// and yields exactly one output beat: an event code (0 none, 1 press, 2 long
// press, 3 repeat, 4 release, 5 long release) and the click count as it stood
// before that sample. A new sample is taken every cycle unless in_stall is
// high; each beat goes through an input register, one stage of counter
// increments and compares that updates the key state, and an output register.
// The output register decouples the two sides: input stalls only when the
// input register is full and the output register holds a beat that the
// consumer is stalling. The thresholds, release delay and the repeat and
// multi-click enables sit in APB registers at byte addresses 0x00, 0x04,
// 0x08, 0x0C and 0x10; write them only while no beat is in flight. Counters
// saturate at their maximum.
module key_press_classifier_unit
    import kpc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // sample channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                key_down,
    // event channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic [EventW-1:0]   event_res,
    output logic [ClickW-1:0]   click_count,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // ---------------- configuration registers ----------------
    logic [CountW-1:0] short_thr_reg;
    logic [CountW-1:0] long_thr_reg;
    logic [CountW-1:0] rel_delay_reg;
    logic              repeat_en_reg;
    logic              multi_en_reg;

    logic [RegIdxW-1:0] reg_idx;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:2];
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_thr_reg <= 16'd2;
            long_thr_reg  <= 16'd100;
            rel_delay_reg <= 16'd30;
            repeat_en_reg <= 1'b1;
            multi_en_reg  <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_SHORT_THR: short_thr_reg <= pwdata[CountW-1:0];
                REG_LONG_THR:  long_thr_reg  <= pwdata[CountW-1:0];
                REG_REL_DELAY: rel_delay_reg <= pwdata[CountW-1:0];
                REG_REPEAT_EN: repeat_en_reg <= pwdata[0];
                REG_MULTI_EN:  multi_en_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SHORT_THR: prdata = {16'd0, short_thr_reg};
            REG_LONG_THR:  prdata = {16'd0, long_thr_reg};
            REG_REL_DELAY: prdata = {16'd0, rel_delay_reg};
            REG_REPEAT_EN: prdata = {31'd0, repeat_en_reg};
            REG_MULTI_EN:  prdata = {31'd0, multi_en_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // ---------------- handshake ----------------
    logic in_valid_reg;
    logic key_down_reg;
    logic out_valid_reg;
    logic out_open;     // output register can take a beat this cycle
    logic step;         // process the sample in the input register

    assign out_open = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && out_open;
    // hold the input only when the sample register is full and cannot drain
    assign in_stall = in_valid_reg && !out_open;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            key_down_reg <= key_down;
        end
    end

    // ---------------- key state ----------------
    logic [CountW-1:0] press_ticks_reg, press_ticks_next;
    phase_t            phase_reg, phase_next;
    logic [CountW-1:0] repeat_mark_reg, repeat_mark_next;
    logic [CountW-1:0] rel_ticks_reg, rel_ticks_next;
    logic [ClickW-1:0] clicks_reg, clicks_next;
    event_t            event_next;

    logic              advanced;
    logic [CountW-1:0] press_inc;
    logic [CountW-1:0] mark_from_press;
    logic [CountW-1:0] rel_inc;

    assign advanced        = press_ticks_reg != CountMax;
    assign press_inc       = advanced ? press_ticks_reg + 16'd1 : press_ticks_reg;
    assign mark_from_press = sat_add(press_inc, long_thr_reg);
    assign rel_inc         = sat_add(rel_ticks_reg, 16'd1);

    always_comb
    begin
        press_ticks_next = press_ticks_reg;
        phase_next       = phase_reg;
        repeat_mark_next = repeat_mark_reg;
        rel_ticks_next   = rel_ticks_reg;
        clicks_next      = clicks_reg;
        event_next       = EV_NONE;

        if (key_down_reg)
        begin
            press_ticks_next = press_inc;
            if (phase_reg == PH_LONG)
            begin
                // arm the first repeat one interval after this sample
                if (repeat_en_reg)
                begin
                    phase_next       = PH_REPEAT;
                    repeat_mark_next = mark_from_press;
                end
            end
            else if (repeat_en_reg && phase_reg == PH_REPEAT && advanced &&
                     repeat_mark_reg == press_inc)
            begin
                event_next       = EV_REPEAT;
                repeat_mark_next = mark_from_press;
            end
            else if (advanced && press_inc == long_thr_reg)
            begin
                phase_next = PH_LONG;
                event_next = EV_LONG;
            end
            else if (advanced && press_inc == short_thr_reg)
            begin
                phase_next = PH_PRESSED;
                event_next = EV_PRESS;
                if (multi_en_reg)
                begin
                    if (clicks_reg != ClickMax)
                    begin
                        clicks_next = clicks_reg + 8'd1;
                    end
                    rel_ticks_next = '0;
                end
            end
        end
        else
        begin
            press_ticks_next = '0;
            unique case (phase_reg) inside
                PH_PRESSED:
                begin
                    if (multi_en_reg)
                    begin
                        // wait out the release delay before closing the run
                        rel_ticks_next = rel_inc;
                        if (rel_inc > rel_delay_reg)
                        begin
                            event_next     = EV_RELEASE;
                            clicks_next    = '0;
                            rel_ticks_next = '0;
                            phase_next     = PH_IDLE;
                        end
                    end
                    else
                    begin
                        event_next = EV_RELEASE;
                        phase_next = PH_IDLE;
                    end
                end
                PH_LONG, PH_REPEAT:
                begin
                    event_next = EV_LONG_RELEASE;
                    if (multi_en_reg)
                    begin
                        clicks_next    = '0;
                        rel_ticks_next = '0;
                    end
                    phase_next = PH_IDLE;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_ticks_reg <= '0;
            phase_reg       <= PH_IDLE;
            repeat_mark_reg <= '0;
            rel_ticks_reg   <= '0;
            clicks_reg      <= '0;
        end
        else if (step)
        begin
            press_ticks_reg <= press_ticks_next;
            phase_reg       <= phase_next;
            repeat_mark_reg <= repeat_mark_next;
            rel_ticks_reg   <= rel_ticks_next;
            clicks_reg      <= clicks_next;
        end
    end

    // ---------------- output register ----------------
    logic [EventW-1:0] event_reg;
    logic [ClickW-1:0] click_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_open)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // report the click count as it stood before this sample
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            event_reg       <= event_next;
            click_count_reg <= clicks_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_res   = event_reg;
    assign click_count = click_count_reg;

endmodule

// File: verif/key_press_classifier_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_press_classifier_unit_tb
// Drives key samples through the classifier and checks every event beat
// against a cycle-free behavioral copy of the classifier kept in the bench.
// Covers reset values, each event kind, register extremes, random press and
// release sequences under input and output throttling, a long output hold-off
// and click counter saturation.
// ----------------------------------------------------------------------------
module key_press_classifier_unit_tb;
    import kpc_pkg::*;

    // Pipeline depth from sample beat to event beat
    localparam int Latency = 2;
    // An index with no register behind it; writes must be ignored
    localparam logic [RegIdxW-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        event_t             ev;
        logic [ClickW-1:0]  clicks;
    } key_event_t;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT pins. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               key_down = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [EventW-1:0]  event_res;
    logic [ClickW-1:0]  click_count;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    key_press_classifier_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .key_down    (key_down),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_res   (event_res),
        .click_count (click_count),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    key_event_t         expected_events[$];  // predicted event beats, oldest first
    int                 error_count = 0;
    int                 samples_sent = 0;
    int                 gap_pct = 0;         // chance per cycle the sender idles
    int                 stall_pct = 0;       // chance per cycle the receiver stalls
    int                 hold_off_request = 0;
    int                 hold_off_left = 0;

    // Classifier copy: registers (at reset values) and key state
    logic [CountW-1:0]  cfg_short = 16'd2;
    logic [CountW-1:0]  cfg_long = 16'd100;
    logic [CountW-1:0]  cfg_delay = 16'd30;
    logic               cfg_repeat = 1'b1;
    logic               cfg_multi = 1'b1;
    logic [CountW-1:0]  held_ticks = '0;
    phase_t             key_phase = PH_IDLE;
    logic [CountW-1:0]  repeat_mark = '0;
    logic [CountW-1:0]  released_ticks = '0;
    logic [ClickW-1:0]  click_run = '0;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic logic [CountW-1:0] add_capped(input logic [CountW-1:0] a,
                                                    input logic [CountW-1:0] b);
        logic [CountW:0] sum;
        sum = a + b;
        return (sum > CountMax) ? CountMax : sum[CountW-1:0];
    endfunction

    // Advance the key state by one sample and return the event it raises.
    // The click count reported is the one standing before this sample.
    function automatic key_event_t classify_tick(input logic down);
        key_event_t res;
        logic       advanced;
        res.ev = EV_NONE;
        res.clicks = click_run;
        if (down)
        begin
            // Compares only fire on a tick where the press counter moved
            advanced = (held_ticks != CountMax);
            if (advanced)
                held_ticks = held_ticks + 1'b1;
            if (key_phase == PH_LONG)
            begin
                if (cfg_repeat)
                begin
                    key_phase = PH_REPEAT;
                    repeat_mark = add_capped(held_ticks, cfg_long);
                end
            end
            else if (cfg_repeat && key_phase == PH_REPEAT && advanced &&
                     repeat_mark == held_ticks)
            begin
                res.ev = EV_REPEAT;
                repeat_mark = add_capped(held_ticks, cfg_long);
            end
            else if (advanced && held_ticks == cfg_long)
            begin
                key_phase = PH_LONG;
                res.ev = EV_LONG;
            end
            else if (advanced && held_ticks == cfg_short)
            begin
                key_phase = PH_PRESSED;
                res.ev = EV_PRESS;
                if (cfg_multi)
                begin
                    if (click_run != ClickMax)
                        click_run = click_run + 1'b1;
                    released_ticks = '0;
                end
            end
        end
        else
        begin
            if (key_phase == PH_PRESSED)
            begin
                if (cfg_multi)
                begin
                    // Multi-click: report only once the key stayed up long enough
                    released_ticks = add_capped(released_ticks, 16'd1);
                    if (released_ticks > cfg_delay)
                    begin
                        res.ev = EV_RELEASE;
                        click_run = '0;
                        released_ticks = '0;
                        key_phase = PH_IDLE;
                    end
                end
                else
                begin
                    res.ev = EV_RELEASE;
                    key_phase = PH_IDLE;
                end
            end
            else if (key_phase == PH_LONG || key_phase == PH_REPEAT)
            begin
                res.ev = EV_LONG_RELEASE;
                if (cfg_multi)
                begin
                    click_run = '0;
                    released_ticks = '0;
                end
                key_phase = PH_IDLE;
            end
            held_ticks = '0;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Mismatch reporting: one line per failure, always counted
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: drive out_stall. A requested hold-off is counted down here,
    // cycle by cycle; otherwise stall at random at the current rate.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_off_request != 0)
        begin
            hold_off_left = hold_off_request;
            hold_off_request = 0;
        end
        if (hold_off_left != 0)
        begin
            out_stall <= 1'b1;
            hold_off_left = hold_off_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // ------------------------------------------------------------------------
    // Event checker: compare each accepted event beat with the oldest
    // prediction, field by field.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_events
        key_event_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_events.size() == 0)
                flag_mismatch($sformatf("event beat with nothing expected: ev=%0d clicks=%0d",
                                        event_res, click_count));
            else
            begin
                want = expected_events.pop_front();
                if (event_res !== want.ev)
                    flag_mismatch($sformatf("event_res got %0d want %0d",
                                            event_res, want.ev));
                if (click_count !== want.clicks)
                    flag_mismatch($sformatf("click_count got %0d want %0d",
                                            click_count, want.clicks));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender: offer one key sample and hold it until the beat is taken.
    // Valid stays high between back-to-back samples; it drops only on an
    // idle cycle, so it is never lowered and raised in the same step.
    // ------------------------------------------------------------------------
    task automatic send_key(input logic down);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            key_down <= 1'($urandom_range(1));   // payload is free while idle
            @(posedge clk);
        end
        in_valid <= 1'b1;
        key_down <= down;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_events.push_back(classify_tick(down));
        samples_sent++;
    endtask

    // Stop sending and wait until every predicted event has arrived, then
    // let the pipeline settle so a stray extra beat would still be caught.
    task automatic drain_events();
        in_valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (Latency + 2)
            @(posedge clk);
    endtask

    // APB write: setup then access, written on the access edge with pready.
    // Bits above the register width carry random junk that must be ignored.
    task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [CountW-1:0] value);
        logic [31:0] keep_mask;
        logic [31:0] word;
        keep_mask = (idx == REG_REPEAT_EN || idx == REG_MULTI_EN) ? 32'h1 : 32'hFFFF;
        word = ($urandom() & ~keep_mask) | ({16'd0, value} & keep_mask);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_SHORT_THR: cfg_short = word[CountW-1:0];
            REG_LONG_THR:  cfg_long = word[CountW-1:0];
            REG_REL_DELAY: cfg_delay = word[CountW-1:0];
            REG_REPEAT_EN: cfg_repeat = word[0];
            REG_MULTI_EN:  cfg_multi = word[0];
            default: ;
        endcase
    endtask

    // Write all five registers once the block is idle
    task automatic configure_all(input logic [CountW-1:0] short_thr,
                                 input logic [CountW-1:0] long_thr,
                                 input logic [CountW-1:0] delay,
                                 input logic rep, input logic multi);
        drain_events();
        write_reg(REG_SHORT_THR, short_thr);
        write_reg(REG_LONG_THR, long_thr);
        write_reg(REG_REL_DELAY, delay);
        write_reg(REG_REPEAT_EN, {{(CountW-1){1'b0}}, rep});
        write_reg(REG_MULTI_EN, {{(CountW-1){1'b0}}, multi});
    endtask

    // Mostly small values so events come often; now and then an extreme
    function automatic logic [CountW-1:0] pick_setting(input int lo, input int hi);
        if ($urandom_range(99) < 12)
        begin
            case ($urandom_range(2))
                0: return 16'd0;
                1: return 16'd1;
                default: return CountMax;
            endcase
        end
        return CountW'($urandom_range(hi, lo));
    endfunction

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        gap_pct = sender_pct;
        stall_pct = receiver_pct;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset values: press at two ticks, short release after 31 released ticks
    task automatic test_reset_values();
        repeat (3)
            send_key(1'b1);
        repeat (32)
            send_key(1'b0);
    endtask

    // Each event kind and each special register setting, on short runs
    task automatic test_directed_events();
        // Press, immediate multi-click release, then press into long and repeat
        configure_all(16'd1, 16'd3, 16'd0, 1'b1, 1'b1);
        write_reg(REG_UNUSED, 16'hFFFF);
        send_key(1'b1);
        send_key(1'b0);
        repeat (7)
            send_key(1'b1);
        send_key(1'b0);

        // Repeat and multi-click off: long holds, release comes at once
        configure_all(16'd1, 16'd3, 16'd0, 1'b0, 1'b0);
        repeat (5)
            send_key(1'b1);
        send_key(1'b0);
        send_key(1'b1);
        send_key(1'b0);

        // Zero thresholds never match; maximum delay never releases
        configure_all(16'd0, 16'd0, CountMax, 1'b1, 1'b1);
        repeat (3)
            send_key(1'b1);
        send_key(1'b0);
    endtask

    // Random press/release sequences with random content, some noise,
    // occasional register changes and occasional full drains.
    task automatic test_random_sequences(input int count);
        int goal;
        int hold;
        int gap;
        int cap_short;
        int cap_long;
        int cap_delay;
        logic [CountW-1:0] new_short;
        goal = samples_sent + count;
        while (samples_sent < goal)
        begin
            if ($urandom_range(99) < 12)
            begin
                new_short = pick_setting(1, 6);
                configure_all(new_short, pick_setting(1, 24), pick_setting(0, 8),
                              1'($urandom_range(1)), 1'($urandom_range(1)));
            end
            else if ($urandom_range(99) < 5)
                drain_events();   // sender pauses until all events are back

            cap_short = (cfg_short == 0 || cfg_short > 40) ? 40 : cfg_short;
            cap_long = (cfg_long == 0 || cfg_long > 40) ? 40 : cfg_long;
            cap_delay = (cfg_delay > 12) ? 12 : cfg_delay;
            if ($urandom_range(7) == 0)
            begin
                // Noise: raw random levels
                repeat ($urandom_range(1, 8))
                    send_key(1'($urandom_range(1)));
            end
            else
            begin
                case ($urandom_range(2))
                    0: hold = $urandom_range(1, cap_short + 1);
                    1: hold = $urandom_range(1, cap_long + 2);
                    default: hold = $urandom_range(cap_long, 3 * cap_long + 3);
                endcase
                // Short gaps build multi-click runs, longer ones let them end
                gap = $urandom_range(1) ? $urandom_range(1, 2)
                                        : $urandom_range(1, cap_delay + 2);
                repeat (hold)
                    send_key(1'b1);
                repeat (gap)
                    send_key(1'b0);
            end
        end
    endtask

    // Hold the event side off for a long stretch while samples keep coming,
    // so the block fills and stalls its input; then drain.
    task automatic test_output_hold_off();
        configure_all(16'd2, 16'd5, 16'd1, 1'b1, 1'b1);
        hold_off_request = 80;
        repeat (4)
        begin
            repeat (8)
                send_key(1'b1);
            repeat (3)
                send_key(1'b0);
        end
        drain_events();
    endtask

    // Push the click count past its maximum, then let the run end
    task automatic test_click_saturation();
        configure_all(16'd1, 16'd0, CountMax, 1'b0, 1'b1);
        repeat (ClickMax + 5)
        begin
            send_key(1'b1);
            send_key(1'b0);
        end
        drain_events();
        write_reg(REG_REL_DELAY, 16'd0);
        send_key(1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles lightly, receiver stalls heavily
        set_idling(20, 54);
        test_reset_values();
        test_directed_events();
        test_random_sequences(40);

        // The other way round
        set_idling(54, 20);
        test_random_sequences(40);
        test_output_hold_off();

        // No idling on either side
        set_idling(0, 0);
        test_random_sequences(40);
        test_click_saturation();

        drain_events();
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: well beyond the slowest correct run
    initial
    begin
        #1_000_000;
        $display("ERROR: run did not finish in time");
        $display("FAILURE");
        $finish;
    end

endmodule

// File: key_press_classifier_unit.f
rtl/kpc_pkg.sv
rtl/key_press_classifier_unit.sv
verif/key_press_classifier_unit_tb.sv
